### hdl/anc_pkg.sv
// Shared widths, limits, result codes and stage types for the asset name classifier.
`timescale 1ns / 1ps
package anc_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned KIND_W = 4;
  localparam int unsigned CNT_W  = 7;

  localparam logic [CNT_W-1:0] TEST_MAX_LENGTH = 7'd121;
  localparam logic [CNT_W-1:0] MAIN_MAX_LENGTH = 7'd32;
  localparam logic [CNT_W-1:0] CNT_MAX         = 7'd127;

  localparam logic [KIND_W-1:0] KIND_INVALID    = 4'd0;
  localparam logic [KIND_W-1:0] KIND_ROOT       = 4'd1;
  localparam logic [KIND_W-1:0] KIND_SUB        = 4'd2;
  localparam logic [KIND_W-1:0] KIND_UNIQUE     = 4'd3;
  localparam logic [KIND_W-1:0] KIND_OWNER      = 4'd4;
  localparam logic [KIND_W-1:0] KIND_QUALIFIER  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_SUBQUAL    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_RESTRICTED = 4'd7;
  localparam logic [KIND_W-1:0] KIND_DEPIN      = 4'd8;

  // One character moving from the input register into the tracker.
  typedef struct packed {
    logic              go;
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } anc_step_t;

endpackage

### hdl/anc_if.sv
// Handshake channel interfaces: character input, class result and configuration write.
`timescale 1ns / 1ps
interface anc_char_if;
  logic                        valid;
  logic                        ready;
  logic [anc_pkg::CHAR_W-1:0]  character;
  logic                        last_char;
  modport source (output valid, output character, output last_char, input ready);
  modport sink (input valid, input character, input last_char, output ready);
endinterface

interface anc_kind_if;
  logic                        valid;
  logic                        ready;
  logic [anc_pkg::KIND_W-1:0]  name_kind;
  modport source (output valid, output name_kind, input ready);
  modport sink (input valid, input name_kind, output ready);
endinterface

interface anc_cfg_if;
  logic valid;
  logic ready;
  logic test_network;
  modport source (output valid, output test_network, input ready);
  modport sink (input valid, input test_network, output ready);
endinterface

### hdl/anc_tracker.sv
// Per-name rule tracker: segment flags and counters updated per character, class decode.
`timescale 1ns / 1ps
module anc_tracker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  anc_pkg::anc_step_t         step_i,
  input  logic                       test_i,
  output logic [anc_pkg::KIND_W-1:0] kind_o
);

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef struct packed {
    logic [anc_pkg::CNT_W-1:0] cnt;
    logic [anc_pkg::CNT_W-1:0] seg_len;
    logic       nb0;      // segment head is not a body character
    logic       nbr;      // some later segment character is not a body character
    logic       h0;       // segment head is a hash
    logic       lead;     // segment head is punctuation
    logic       p1;       // second segment character is punctuation
    logic       dbl;      // doubled punctuation in segment
    logic       lpun;     // last segment character is punctuation
    logic       m0s;
    logic       m0l;
    logic       m1s;
    logic       m1l;
    logic       p_ok;     // closed path segments all valid
    logic       d_ok;     // closed depin segments all valid
    logic       q_first;  // qualifier head segment valid
    logic [1:0] slash_cnt;
    logic       hash_seen;
    logic       u_base;
    logic       u_tag;
    logic       u_tail;
    logic       f_hash;
    logic       f_dollar;
    logic       f_amp;
  } trk_t;

  localparam trk_t TRK_INIT = '{
    cnt: '0, seg_len: '0, nb0: 1'b0, nbr: 1'b0, h0: 1'b0, lead: 1'b0, p1: 1'b0,
    dbl: 1'b0, lpun: 1'b0, m0s: 1'b1, m0l: 1'b1, m1s: 1'b1, m1l: 1'b1,
    p_ok: 1'b1, d_ok: 1'b1, q_first: 1'b0, slash_cnt: 2'd0, hash_seen: 1'b0,
    u_base: 1'b0, u_tag: 1'b1, u_tail: 1'b0, f_hash: 1'b0, f_dollar: 1'b0,
    f_amp: 1'b0
  };

  trk_t trk_q, trk_d;

  function automatic logic is_punct(logic [7:0] c);
    return (c == CH_DOT) || (c == CH_UNDER);
  endfunction

  function automatic logic is_body(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39) || is_punct(c);
  endfunction

  function automatic logic is_tag(logic [7:0] c);
    logic r;
    r = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
        (c >= 8'h30 && c <= 8'h39);
    case (c)
      8'h2D, 8'h40, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h28, 8'h29,
      8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h5F, 8'h2E, 8'h3F, 8'h3A: r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  // Short reserved word, three letters.
  function automatic logic [7:0] word_s(logic [anc_pkg::CNT_W-1:0] i);
    logic [7:0] r;
    case (i)
      7'd0:    r = 8'h58;
      7'd1:    r = 8'h4E;
      7'd2:    r = 8'h41;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Long reserved word; its first six letters form the middle reserved word.
  function automatic logic [7:0] word_l(logic [anc_pkg::CNT_W-1:0] i);
    logic [7:0] r;
    case (i)
      7'd0:    r = 8'h4E;
      7'd1:    r = 8'h45;
      7'd2:    r = 8'h55;
      7'd3:    r = 8'h52;
      7'd4:    r = 8'h41;
      7'd5:    r = 8'h49;
      7'd6:    r = 8'h43;
      7'd7:    r = 8'h4F;
      7'd8:    r = 8'h49;
      7'd9:    r = 8'h4E;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic res0(trk_t st);
    return (st.m0s && st.seg_len == 7'd3) ||
           (st.m0l && (st.seg_len == 7'd6 || st.seg_len == 7'd10));
  endfunction

  function automatic logic res1(trk_t st);
    return (st.m1s && st.seg_len == 7'd4) ||
           (st.m1l && (st.seg_len == 7'd7 || st.seg_len == 7'd11));
  endfunction

  function automatic logic seg_clean(trk_t st);
    return (st.seg_len != 7'd0) && !st.nb0 && !st.nbr && !st.dbl && !st.lead && !st.lpun;
  endfunction

  function automatic logic path_final(trk_t st);
    return st.p_ok && seg_clean(st) &&
           ((st.slash_cnt != 2'd0) || (st.seg_len >= 7'd3 && !res0(st)));
  endfunction

  function automatic logic qual_seg(trk_t st);
    return (st.seg_len >= 7'd4) && st.h0 && !st.nbr && !st.dbl && !st.p1 && !st.lpun &&
           !res1(st);
  endfunction

  function automatic logic qual_final(trk_t st);
    logic r;
    r = 1'b0;
    if (st.slash_cnt == 2'd0) begin
      r = qual_seg(st);
    end else if (st.slash_cnt == 2'd1) begin
      r = st.q_first && (st.seg_len >= 7'd2) && st.h0 && !st.nbr && !st.dbl && !st.lpun;
    end
    return r;
  endfunction

  function automatic logic restr_final(trk_t st);
    return (st.slash_cnt == 2'd0) && (st.cnt >= 7'd4) && !st.nbr && !st.dbl && !st.lpun;
  endfunction

  function automatic logic depin_final(trk_t st);
    logic r;
    if (st.slash_cnt == 2'd0) begin
      r = (st.seg_len >= 7'd4) && !st.nbr;
    end else begin
      r = st.d_ok && (st.seg_len >= 7'd3) && !st.nbr && !st.nb0;
    end
    return r;
  endfunction

  function automatic trk_t step(trk_t st, logic [7:0] c);
    trk_t                      ns;
    logic                      pu;
    logic                      bd;
    logic [anc_pkg::CNT_W-1:0] i;
    ns = st;
    pu = is_punct(c);
    bd = is_body(c);
    i  = st.seg_len;
    if (st.cnt == 7'd0) begin
      ns.f_hash   = (c == CH_HASH);
      ns.f_dollar = (c == CH_DOLLAR);
      ns.f_amp    = (c == CH_AMP);
    end
    if (st.cnt != anc_pkg::CNT_MAX) begin
      ns.cnt = st.cnt + 7'd1;
    end
    // The text before the first hash must be a full path name.
    if (c == CH_HASH && !st.hash_seen) begin
      ns.hash_seen = 1'b1;
      ns.u_base    = path_final(st);
    end else if (st.hash_seen) begin
      ns.u_tail = 1'b1;
      ns.u_tag  = st.u_tag && is_tag(c);
    end
    if (c == CH_SLASH) begin
      // Close the segment and open a new one.
      ns.p_ok = st.p_ok && seg_clean(st) &&
                ((st.slash_cnt != 2'd0) || (i >= 7'd3 && !res0(st)));
      ns.d_ok = st.d_ok && (i >= 7'd3) && !st.nbr && ((st.slash_cnt == 2'd0) || !st.nb0);
      if (st.slash_cnt == 2'd0) begin
        ns.q_first = qual_seg(st);
      end
      if (st.slash_cnt != 2'd3) begin
        ns.slash_cnt = st.slash_cnt + 2'd1;
      end
      ns.seg_len = '0;
      ns.nb0     = 1'b0;
      ns.nbr     = 1'b0;
      ns.h0      = 1'b0;
      ns.lead    = 1'b0;
      ns.p1      = 1'b0;
      ns.dbl     = 1'b0;
      ns.lpun    = 1'b0;
      ns.m0s     = 1'b1;
      ns.m0l     = 1'b1;
      ns.m1s     = 1'b1;
      ns.m1l     = 1'b1;
    end else begin
      if (i == 7'd0) begin
        ns.nb0  = !bd;
        ns.h0   = (c == CH_HASH);
        ns.lead = pu;
      end else begin
        ns.nbr = st.nbr || !bd;
      end
      if (i == 7'd1) begin
        ns.p1 = pu;
      end
      ns.dbl  = st.dbl || (pu && st.lpun);
      ns.lpun = pu;
      if (i < 7'd3) begin
        ns.m0s = st.m0s && (c == word_s(i));
      end
      if (i < 7'd10) begin
        ns.m0l = st.m0l && (c == word_l(i));
      end
      if (i >= 7'd1 && i <= 7'd3) begin
        ns.m1s = st.m1s && (c == word_s(i - 7'd1));
      end
      if (i >= 7'd1 && i <= 7'd10) begin
        ns.m1l = st.m1l && (c == word_l(i - 7'd1));
      end
      if (i != anc_pkg::CNT_MAX) begin
        ns.seg_len = i + 7'd1;
      end
    end
    return ns;
  endfunction

  logic [anc_pkg::CNT_W-1:0] full_len;

  always_comb begin
    trk_d    = step(trk_q, step_i.character);
    full_len = test_i ? anc_pkg::TEST_MAX_LENGTH : anc_pkg::MAIN_MAX_LENGTH;
    kind_o   = anc_pkg::KIND_INVALID;
    if (trk_d.cnt > full_len) begin
      kind_o = anc_pkg::KIND_INVALID;
    end else if (step_i.character == CH_BANG) begin
      // Owner: judge the base from the state before the closing mark.
      if (path_final(trk_q) || (trk_q.f_amp && test_i && depin_final(trk_q))) begin
        kind_o = anc_pkg::KIND_OWNER;
      end
    end else if (trk_d.f_hash) begin
      if (qual_final(trk_d)) begin
        kind_o = (trk_d.slash_cnt != 2'd0) ? anc_pkg::KIND_SUBQUAL : anc_pkg::KIND_QUALIFIER;
      end
    end else if (trk_d.f_dollar) begin
      if (restr_final(trk_d)) begin
        kind_o = anc_pkg::KIND_RESTRICTED;
      end
    end else if (trk_d.f_amp) begin
      if (test_i && depin_final(trk_d)) begin
        kind_o = anc_pkg::KIND_DEPIN;
      end
    end else if (trk_d.hash_seen) begin
      if (trk_d.u_base && trk_d.u_tag && trk_d.u_tail) begin
        kind_o = anc_pkg::KIND_UNIQUE;
      end
    end else if (trk_d.cnt > full_len - 7'd1) begin
      kind_o = anc_pkg::KIND_INVALID;
    end else if (path_final(trk_d)) begin
      kind_o = (trk_d.slash_cnt != 2'd0) ? anc_pkg::KIND_SUB : anc_pkg::KIND_ROOT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q <= TRK_INIT;
    end else if (step_i.go) begin
      // Start fresh after the closing character.
      trk_q <= step_i.last_char ? TRK_INIT : trk_d;
    end
  end

endmodule

### hdl/asset_name_classifier_core.sv
// Asset name classifier top level: input register, rule tracker, result register, config.
//
//  channel  | dir | payload            | transaction
//  char_i   | in  | character, last   | one name character
//  kind_o   | out | name_kind          | one class code per name
//  cfg_i    | in  | test_network       | select network limits
//
// One character per cycle if not stalled: input register, then tracker, result register.
// A name's class is registered once its last character leaves the input register.
// Reset clears the tracker, both valid flags and test_network.
// A stalled result holds only the register carrying a name's last character;
// other characters keep flowing.
`timescale 1ns / 1ps
module asset_name_classifier_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  anc_char_if.sink  char_i,
  anc_kind_if.source kind_o,
  anc_cfg_if.sink   cfg_i
);

  logic                        in_valid_q;
  logic [anc_pkg::CHAR_W-1:0]  in_char_q;
  logic                        in_last_q;
  logic                        out_valid_q;
  logic [anc_pkg::KIND_W-1:0]  out_kind_q;
  logic                        test_q;
  logic                        out_free;
  anc_pkg::anc_step_t          step;
  logic [anc_pkg::KIND_W-1:0]  kind;

  assign out_free       = !out_valid_q || kind_o.ready;
  assign step.go        = in_valid_q && (!in_last_q || out_free);
  assign step.character = in_char_q;
  assign step.last_char = in_last_q;
  assign char_i.ready   = !in_valid_q || step.go;
  assign cfg_i.ready    = 1'b1;
  assign kind_o.valid   = out_valid_q;
  assign kind_o.name_kind = out_kind_q;

  anc_tracker u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .test_i (test_q),
    .kind_o (kind)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      test_q      <= 1'b0;
    end else begin
      if (char_i.valid && char_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (step.go) begin
        in_valid_q <= 1'b0;
      end
      if (step.go && in_last_q) begin
        out_valid_q <= 1'b1;
      end else if (kind_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        test_q <= cfg_i.test_network;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      in_char_q <= char_i.character;
      in_last_q <= char_i.last_char;
    end
    if (step.go && in_last_q) begin
      out_kind_q <= kind;
    end
  end

endmodule

### verif/tb.sv
// Self-checking testbench for the asset name classifier: directed and random names, both networks.
`timescale 1ns / 1ps
module tb;
  import anc_pkg::*;

  localparam int unsigned STORE_LEN   = 127;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned ITEMS_PHASE = 450;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UND   = 8'h5F;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_AMP   = 8'h26;

  // reserved words, right-aligned, first character in the highest occupied byte
  localparam logic [87:0] RSV_WORD [6] = '{
    88'h584E41, 88'h4E4555524149, 88'h4E4555524149434F494E,
    88'h23584E41, 88'h234E4555524149, 88'h234E4555524149434F494E};
  localparam int RSV_LEN [6] = '{3, 6, 10, 4, 7, 11};
  localparam string TAG_SET = "abcz-@$%&*()[]{}_.?:AZ09";

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  anc_char_if char_if ();
  anc_kind_if kind_if ();
  anc_cfg_if  cfg_if ();

  asset_name_classifier_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if.sink),
    .kind_o (kind_if.source),
    .cfg_i  (cfg_if.sink)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  char_item_t      pending_chars [$];
  logic [KIND_W-1:0] expected_kinds [$];
  logic [7:0]      draft [$];
  logic [7:0]      name_buf [STORE_LEN];
  int unsigned     name_len;
  logic            net_test;
  logic            sender_hold;
  int unsigned     err_count, names_sent, kinds_seen, chars_sent;
  int unsigned     cycle_count;
  int unsigned     kind_hist [9];

  // ---------------- predictor ----------------
  function automatic bit is_body(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") || c == CH_UND || c == CH_DOT;
  endfunction

  function automatic bit is_tag(logic [7:0] c);
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9"))
      return 1'b1;
    case (c)
      "-", "@", "$", "%", "&", "*", "(", ")", "[", "]", "{", "}", "_", ".", "?", ":":
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_punct(logic [7:0] c);
    return c == CH_DOT || c == CH_UND;
  endfunction

  function automatic int find_ch(int s, int n, logic [7:0] c);
    for (int i = 0; i < n; i++)
      if (name_buf[s+i] == c) return i;
    return n;
  endfunction

  function automatic bit all_body(int s, int n);
    if (n == 0) return 1'b0;
    for (int i = 0; i < n; i++)
      if (!is_body(name_buf[s+i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit has_double(int s, int n);
    for (int i = 0; i + 1 < n; i++)
      if (is_punct(name_buf[s+i]) && is_punct(name_buf[s+i+1])) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit lead_p(int s, int n);
    return n > 0 && is_punct(name_buf[s]);
  endfunction

  function automatic bit trail_p(int s, int n);
    return n > 0 && is_punct(name_buf[s+n-1]);
  endfunction

  function automatic bit is_reserved(int s, int n);
    bit hit;
    for (int k = 0; k < 6; k++) begin
      hit = (n == RSV_LEN[k]);
      for (int i = 0; hit && i < n; i++)
        if (name_buf[s+i] != RSV_WORD[k][8*(n-1-i) +: 8]) hit = 1'b0;
      if (hit) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit clean_seg(int s, int n);
    return all_body(s, n) && !has_double(s, n) && !lead_p(s, n) && !trail_p(s, n);
  endfunction

  function automatic bit root_seg(int s, int n);
    return n >= 3 && clean_seg(s, n) && !is_reserved(s, n);
  endfunction

  function automatic bit qual_seg(int s, int n);
    if (n < 4 || name_buf[s] != CH_HASH) return 1'b0;
    if (!all_body(s + 1, n - 1) || has_double(s, n)) return 1'b0;
    if (is_punct(name_buf[s+1]) || trail_p(s, n)) return 1'b0;
    return !is_reserved(s, n);
  endfunction

  function automatic bit subqual_seg(int s, int n);
    if (n < 2 || name_buf[s] != CH_HASH) return 1'b0;
    if (!all_body(s + 1, n - 1)) return 1'b0;
    return !has_double(s, n) && !lead_p(s, n) && !trail_p(s, n);
  endfunction

  function automatic bit path_ok(int n);
    int start;
    bit first;
    start = 0;
    first = 1'b1;
    if (n == 0) return 1'b0;
    for (int i = 0; i <= n; i++) begin
      if (i == n || name_buf[i] == CH_SLASH) begin
        if (first) begin
          if (!root_seg(start, i - start)) return 1'b0;
          first = 1'b0;
        end else if (!(i - start >= 1 && clean_seg(start, i - start))) begin
          return 1'b0;
        end
        start = i + 1;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit restricted_ok(int n);
    if (n < 4 || name_buf[0] != CH_DOLL) return 1'b0;
    if (!all_body(1, n - 1)) return 1'b0;
    if (has_double(0, n) || lead_p(0, n) || trail_p(0, n)) return 1'b0;
    return !is_reserved(0, n);
  endfunction

  function automatic bit qualifier_ok(int n);
    int p;
    p = find_ch(0, n, CH_SLASH);
    if (!qual_seg(0, p)) return 1'b0;
    if (p == n) return 1'b1;
    if (find_ch(p + 1, n - p - 1, CH_SLASH) != n - p - 1) return 1'b0;
    return subqual_seg(p + 1, n - p - 1);
  endfunction

  function automatic bit unique_ok(int n);
    int h, tl;
    h = find_ch(0, n, CH_HASH);
    if (h == n) return 1'b0;
    tl = n - h - 1;
    if (find_ch(h + 1, tl, CH_HASH) != tl) return 1'b0;
    if (!path_ok(h) || tl < 1) return 1'b0;
    for (int i = 0; i < tl; i++)
      if (!is_tag(name_buf[h+1+i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit depin_ok(int n);
    int sl, start;
    if (n < 1 || name_buf[0] != CH_AMP) return 1'b0;
    sl = find_ch(0, n, CH_SLASH);
    if (sl == n) return n >= 4 && all_body(1, n - 1);
    if (sl < 2 || !all_body(1, sl - 1) || sl + 1 >= n) return 1'b0;
    for (int i = sl + 1; i < n; i++)
      if (!(is_body(name_buf[i]) || name_buf[i] == CH_SLASH)) return 1'b0;
    start = 0;
    for (int i = 0; i <= n; i++) begin
      if (i == n || name_buf[i] == CH_SLASH) begin
        if (i - start < 3) return 1'b0;
        start = i + 1;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [KIND_W-1:0] classify_name(int n, bit test);
    int full;
    full = test ? int'(TEST_MAX_LENGTH) : int'(MAIN_MAX_LENGTH);
    if (n == 0 || n > full) return KIND_INVALID;
    if (name_buf[n-1] == CH_BANG) begin
      // owner base is the name without its trailing bang
      if (n - 1 == 0) return KIND_INVALID;
      if (path_ok(n - 1)) return KIND_OWNER;
      if (name_buf[0] == CH_AMP && test && depin_ok(n - 1)) return KIND_OWNER;
      return KIND_INVALID;
    end
    if (name_buf[0] == CH_HASH) begin
      if (!qualifier_ok(n)) return KIND_INVALID;
      return find_ch(0, n, CH_SLASH) != n ? KIND_SUBQUAL : KIND_QUALIFIER;
    end
    if (name_buf[0] == CH_DOLL) return restricted_ok(n) ? KIND_RESTRICTED : KIND_INVALID;
    if (name_buf[0] == CH_AMP) return (test && depin_ok(n)) ? KIND_DEPIN : KIND_INVALID;
    if (find_ch(0, n, CH_HASH) != n) return unique_ok(n) ? KIND_UNIQUE : KIND_INVALID;
    if (n > full - 1) return KIND_INVALID;
    if (find_ch(0, n, CH_SLASH) != n) return path_ok(n) ? KIND_SUB : KIND_INVALID;
    if (n < 3) return KIND_INVALID;
    return root_seg(0, n) ? KIND_ROOT : KIND_INVALID;
  endfunction

  // ---------------- driver ----------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  int unsigned send_gap, recv_gap;
  logic        burst_mode;

  always @(posedge clk_i) begin
    char_item_t nxt;
    logic       take;
    if (rst_ni) begin
      if (char_if.valid && char_if.ready) begin
        if (name_len < STORE_LEN) begin
          name_buf[name_len] = char_if.character;
          name_len++;
        end
        chars_sent++;
        if (char_if.last_char) begin
          expected_kinds.push_back(classify_name(name_len, net_test));
          name_len = 0;
          names_sent++;
        end
      end
      if (char_if.valid && !char_if.ready) begin
        take = 1'b0;
      end else if (send_gap > 0 && !burst_mode) begin
        send_gap--;
        take = 1'b0;
        char_if.valid <= 1'b0;
      end else if (pending_chars.size() > 0 && !sender_hold) begin
        take = 1'b1;
      end else begin
        take = 1'b0;
        char_if.valid <= 1'b0;
      end
      if (take) begin
        nxt = pending_chars.pop_front();
        char_if.valid     <= 1'b1;
        char_if.character <= nxt.ch;
        char_if.last_char <= nxt.last;
        send_gap = pick_gap();
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    logic [KIND_W-1:0] want;
    if (rst_ni) begin
      cycle_count++;
      if ($urandom_range(0, 499) == 0) burst_mode <= ~burst_mode;
      if (kind_if.valid && kind_if.ready) begin
        kinds_seen++;
        if (expected_kinds.size() == 0) begin
          $error("name_kind: result with no name pending, got %0d", kind_if.name_kind);
          err_count++;
        end else begin
          want = expected_kinds.pop_front();
          if (want <= KIND_DEPIN) kind_hist[want]++;
          if (kind_if.name_kind !== want) begin
            $error("name_kind mismatch: expected %0d, actual %0d", want, kind_if.name_kind);
            err_count++;
          end
        end
      end
      if (recv_gap > 0 && !burst_mode) begin
        recv_gap--;
        kind_if.ready <= 1'b0;
      end else begin
        kind_if.ready <= 1'b1;
        recv_gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic commit_draft();
    char_item_t it;
    foreach (draft[i]) begin
      it.ch   = draft[i];
      it.last = (i == draft.size() - 1);
      pending_chars.push_back(it);
    end
    draft.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
    commit_draft();
  endtask

  task automatic add_word(int k);
    for (int i = 0; i < RSV_LEN[k]; i++)
      draft.push_back(RSV_WORD[k][8*(RSV_LEN[k]-1-i) +: 8]);
  endtask

  task automatic add_seg(int lo, int hi);
    int n, r;
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0) draft.push_back(CH_DOT);
      else if (r == 1) draft.push_back(CH_UND);
      else if (r < 6) draft.push_back(8'($urandom_range("0", "9")));
      else draft.push_back(8'($urandom_range("A", "Z")));
    end
  endtask

  task automatic add_path();
    add_seg(3, 7);
    repeat ($urandom_range(0, 2)) begin
      draft.push_back(CH_SLASH);
      add_seg(1, 5);
    end
  endtask

  task automatic add_filled(int n);
    repeat (n) draft.push_back(8'($urandom_range("A", "Z")));
  endtask

  task automatic make_random_name();
    int pos;
    case ($urandom_range(0, 10))
      0: add_seg(3, 8);
      1: begin
        add_seg(3, 6);
        repeat ($urandom_range(1, 3)) begin
          draft.push_back(CH_SLASH);
          add_seg(1, 5);
        end
      end
      2: begin
        add_path();
        draft.push_back(CH_HASH);
        repeat ($urandom_range(1, 6)) draft.push_back(TAG_SET[$urandom_range(0, TAG_SET.len()-1)]);
      end
      3: begin
        add_path();
        draft.push_back(CH_BANG);
      end
      4: begin
        draft.push_back(CH_HASH);
        add_seg(3, 8);
        if ($urandom_range(0, 1)) begin
          draft.push_back(CH_SLASH);
          draft.push_back(CH_HASH);
          add_seg(1, 5);
        end
      end
      5: begin
        draft.push_back(CH_DOLL);
        add_seg(2, 8);
      end
      6: begin
        draft.push_back(CH_AMP);
        add_seg(2, 6);
        repeat ($urandom_range(0, 2)) begin
          draft.push_back(CH_SLASH);
          add_seg(2, 6);
        end
        if ($urandom_range(0, 3) == 0) draft.push_back(CH_BANG);
      end
      7: begin
        case ($urandom_range(0, 3))
          0: draft.push_back(CH_HASH);
          1: draft.push_back(CH_DOLL);
          default: ;
        endcase
        add_word($urandom_range(0, 5));
        if ($urandom_range(0, 2) == 0) add_seg(1, 3);
      end
      8: begin
        // long names: mostly around the main limit, a few around the test limit
        if ($urandom_range(0, 3) == 0) add_filled($urandom_range(115, 135));
        else add_filled($urandom_range(28, 36));
      end
      9: repeat ($urandom_range(1, 10)) draft.push_back(8'($urandom_range(1, 255)));
      default: add_seg(1, 4);
    endcase
    if ($urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, draft.size() - 1);
      case ($urandom_range(0, 5))
        0: draft[pos] = CH_DOT;
        1: draft[pos] = CH_SLASH;
        2: draft[pos] = CH_HASH;
        3: draft[pos] = "a";
        4: draft[pos] = CH_BANG;
        default: draft[pos] = 8'($urandom_range(1, 255));
      endcase
    end
    commit_draft();
  endtask

  task automatic wait_idle();
    while (pending_chars.size() != 0 || expected_kinds.size() != 0 || char_if.valid)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_network(logic val);
    wait_idle();
    cfg_if.valid        <= 1'b1;
    cfg_if.test_network <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    net_test = val;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_text("A");
    send_text("AB");
    send_text("ABC");
    send_text("A.B_C");
    send_text("A..B");
    send_text(".ABC");
    send_text("ABC_");
    send_text("ABC/D.E");
    send_text("ABC/");
    send_text("ABC#tag{x}");
    send_text("ABC#");
    send_text("ABC/D!");
    send_text("!");
    send_text("#ABC");
    send_text("#ABCD/#X1");
    send_text("$ABCD");
    send_text("&ABC/DEF");
    send_text("&AB/CDE!");
    send_text("abc");
    add_word(0);
    commit_draft();
    draft.push_back(CH_HASH);
    add_word(2);
    commit_draft();
    draft.push_back(CH_DOLL);
    add_word(1);
    commit_draft();
    add_filled(31);
    commit_draft();
    add_filled(32);
    commit_draft();
    draft.push_back(8'hFF);
    draft.push_back(8'h01);
    commit_draft();
    add_filled(121);
    commit_draft();
    add_filled(130);
    commit_draft();
  endtask

  initial begin
    char_if.valid        = 1'b0;
    char_if.character    = '0;
    char_if.last_char    = 1'b0;
    kind_if.ready        = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.test_network  = 1'b0;
    net_test    = 1'b0;
    sender_hold = 1'b0;
    burst_mode  = 1'b0;
    name_len = 0;
    err_count = 0; names_sent = 0; kinds_seen = 0; chars_sent = 0; cycle_count = 0;
    send_gap = 0; recv_gap = 0;
    foreach (kind_hist[i]) kind_hist[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      write_network(ph[0]);
      if (ph < 2) run_directed();
      while (chars_sent + pending_chars.size() < (ph + 1) * ITEMS_PHASE) begin
        // hold the sender until every outstanding class has come back
        if ($urandom_range(0, 60) == 0) begin
          sender_hold = 1'b1;
          while (expected_kinds.size() != 0 || char_if.valid) @(posedge clk_i);
          sender_hold = 1'b0;
        end
        make_random_name();
        while (pending_chars.size() > 40) @(posedge clk_i);
      end
    end
    write_network(1'b0);
    wait_idle();

    $display("covered %0d names (%0d characters) on both networks, %0d classes checked",
             names_sent, chars_sent, kinds_seen);
    $display("class counts 0..8: %0d %0d %0d %0d %0d %0d %0d %0d %0d", kind_hist[0],
             kind_hist[1], kind_hist[2], kind_hist[3], kind_hist[4], kind_hist[5],
             kind_hist[6], kind_hist[7], kind_hist[8]);
    if (err_count == 0 && expected_kinds.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
